@@ rtl/igf_pkg.sv @@
`default_nettype none

package igf_pkg;

   // Field widths fixed by the transaction format
   localparam int ADDR_BITS   = 64;
   localparam int REGION_BITS = 16;
   localparam int COUNT_BITS  = 9;

   // Request modes
   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_READ   = 2'd2;

   // Response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   // One table entry as held in the span memory
   typedef struct packed {
      logic [ADDR_BITS-1:0]   start;
      logic [ADDR_BITS-1:0]   size;
      logic [ADDR_BITS-1:0]   offset;
      logic [REGION_BITS-1:0] region;
   } entry_type;

endpackage

`default_nettype wire

@@ rtl/interval_gap_fill_table.sv @@
`default_nettype none

// Sorted table of non-overlapping address spans held in one span memory.
// Request channel (req_*): mode clear, insert or read, with the span fields
// and an entry index. Response channel (rsp_*): one transaction per request
// with status, pieces added, the entry count and the entry read.
// A request is taken only while the sequencer is idle; the response sits in
// an output register, so the next request is taken while it waits.
// Clear, unused modes and out-of-range reads go straight to the finish state;
// a valid read first waits on the registered memory read. Insert walks the
// table entry by entry and, for each piece added, moves the upper entries up
// one slot, all through the single read and single write port of the memory.
// If rsp_ready stays low, a finished result waits in the sequencer until the
// output register frees; no request is taken meanwhile.
// Reset empties the table (entry count zero) and drops any response; the
// memory contents are not cleared and are never read before being written.

module interval_gap_fill_table
   import igf_pkg::*;
#(
   parameter int TABLE_DEPTH    = 256,
   parameter int REGION_ID_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic [1:0]             req_mode,
   input  wire logic [REGION_BITS-1:0] req_region_id,
   input  wire logic [ADDR_BITS-1:0]   req_region_base,
   input  wire logic [ADDR_BITS-1:0]   req_span_start,
   input  wire logic [ADDR_BITS-1:0]   req_span_size,
   input  wire logic [7:0]             req_entry_index,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [1:0]             rsp_status,
   output      logic [COUNT_BITS-1:0]  rsp_pieces_added,
   output      logic [COUNT_BITS-1:0]  rsp_entry_count,
   output      logic [ADDR_BITS-1:0]   rsp_read_start,
   output      logic [ADDR_BITS-1:0]   rsp_read_size,
   output      logic [ADDR_BITS-1:0]   rsp_read_offset,
   output      logic [REGION_BITS-1:0] rsp_read_region
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = (CW > 8) ? CW : 8;
   localparam int RW = (REGION_ID_BITS < REGION_BITS) ? REGION_ID_BITS : REGION_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_RDWAIT, S_WALK, S_LOAD, S_GAP, S_SH_RD, S_SH_WR,
      S_ADV, S_SKIP, S_STEP, S_MOVE, S_TAIL, S_FIN
   } state_type;

   state_type state_ff;

   logic [CW-1:0]          count_ff, i_ff, k_ff, pos_ff, added_ff;
   logic [1:0]             status_ff;
   logic [ADDR_BITS-1:0]   cur_ff, left_ff, offs_ff, es_ff, elo_ff;
   logic [ADDR_BITS-1:0]   sz_ff, room_ff, step_ff;
   logic                   ehi_ff, past_ff, tail_ff;
   logic [REGION_BITS-1:0] region_ff;
   entry_type              read_ff;

   logic                   rsp_valid_ff;
   logic [1:0]             rsp_status_ff;
   logic [COUNT_BITS-1:0]  rsp_added_ff, rsp_count_ff;
   entry_type              rsp_entry_ff;

   // Memory port signals
   logic          mem_rd_en, mem_wr_en;
   logic [AW-1:0] mem_rd_addr, mem_wr_addr;
   entry_type     mem_rd_data, mem_wr_data;

   igf_mem #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // Handshake and decode
   logic req_fire, idx_ok, walk_go, has_room, shift_more;
   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign idx_ok     = IW'(req_entry_index) < IW'(count_ff);
   assign walk_go    = (i_ff < count_ff) && (left_ff != '0) && !past_ff;
   assign has_room   = count_ff < CW'(TABLE_DEPTH);
   assign shift_more = k_ff > pos_ff;

   // Gap before the current entry
   logic [ADDR_BITS-1:0] gap_c, sz_c;
   assign gap_c = es_ff - cur_ff;
   assign sz_c  = (gap_c < left_ff) ? gap_c : left_ff;

   // Part covered by the current entry
   logic                 skip_ok;
   logic [ADDR_BITS-1:0] room_c, step_c;
   assign skip_ok = (left_ff != '0) && (cur_ff >= es_ff) && (ehi_ff || (cur_ff < elo_ff));
   assign room_c  = ehi_ff ? ('0 - cur_ff) : (elo_ff - cur_ff);

   always_comb begin
      if (ehi_ff) begin
         if (room_ff == '0) begin
            step_c = left_ff;
         end else if ((left_ff - room_ff) < elo_ff) begin
            step_c = left_ff;
         end else begin
            step_c = room_ff + elo_ff;
         end
      end else begin
         step_c = (room_ff < left_ff) ? room_ff : left_ff;
      end
   end

   // Cursor move with carry out past the address space
   logic [ADDR_BITS:0] move_sum;
   logic               past_c;
   assign move_sum = {1'b0, cur_ff} + {1'b0, step_ff};
   assign past_c   = move_sum[ADDR_BITS] ||
                     ((move_sum[ADDR_BITS-1:0] == '0) && (step_ff != '0));

   // Memory access per state
   always_comb begin
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = k_ff[AW-1:0];
      mem_wr_data = mem_rd_data;
      case (state_ff)
         S_IDLE: begin
            mem_rd_en   = req_fire && (req_mode == MODE_READ) && idx_ok;
            mem_rd_addr = AW'(req_entry_index);
         end
         S_WALK: begin
            mem_rd_en   = walk_go;
            mem_rd_addr = i_ff[AW-1:0];
         end
         S_SH_RD: begin
            mem_rd_en   = shift_more;
            mem_rd_addr = AW'(k_ff - CW'(1));
            mem_wr_en   = !shift_more;
            mem_wr_addr = pos_ff[AW-1:0];
            mem_wr_data.start  = cur_ff;
            mem_wr_data.size   = tail_ff ? left_ff : sz_ff;
            mem_wr_data.offset = offs_ff;
            mem_wr_data.region = region_ff;
         end
         S_SH_WR: begin
            mem_wr_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         added_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // S_FIN reloads the output register itself
         if (rsp_valid_ff && rsp_ready && (state_ff != S_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  status_ff <= STATUS_OK;
                  added_ff  <= '0;
                  read_ff   <= '0;
                  case (req_mode)
                     MODE_CLEAR: begin
                        count_ff <= '0;
                        state_ff <= S_FIN;
                     end
                     MODE_INSERT: begin
                        cur_ff    <= req_span_start;
                        left_ff   <= req_span_size;
                        offs_ff   <= req_span_start - req_region_base;
                        past_ff   <= 1'b0;
                        i_ff      <= '0;
                        region_ff <= REGION_BITS'(req_region_id[RW-1:0]);
                        state_ff  <= S_WALK;
                     end
                     MODE_READ: begin
                        if (idx_ok) begin
                           state_ff <= S_RDWAIT;
                        end else begin
                           status_ff <= STATUS_RANGE;
                           state_ff  <= S_FIN;
                        end
                     end
                     default: begin
                        state_ff <= S_FIN;
                     end
                  endcase
               end
            end
            S_RDWAIT: begin
               read_ff  <= mem_rd_data;
               state_ff <= S_FIN;
            end
            S_WALK: begin
               if (walk_go) begin
                  state_ff <= S_LOAD;
               end else if ((left_ff != '0) && !past_ff) begin
                  state_ff <= S_TAIL;
               end else begin
                  state_ff <= S_FIN;
               end
            end
            S_LOAD: begin
               es_ff              <= mem_rd_data.start;
               {ehi_ff, elo_ff}   <= {1'b0, mem_rd_data.start} + {1'b0, mem_rd_data.size};
               state_ff           <= S_GAP;
            end
            S_GAP: begin
               if (cur_ff < es_ff) begin
                  sz_ff <= sz_c;
                  if (has_room) begin
                     k_ff     <= count_ff;
                     pos_ff   <= i_ff;
                     tail_ff  <= 1'b0;
                     state_ff <= S_SH_RD;
                  end else begin
                     status_ff <= STATUS_FULL;
                     state_ff  <= S_ADV;
                  end
               end else begin
                  state_ff <= S_SKIP;
               end
            end
            S_SH_RD: begin
               if (shift_more) begin
                  state_ff <= S_SH_WR;
               end else begin
                  count_ff <= count_ff + CW'(1);
                  added_ff <= added_ff + CW'(1);
                  if (tail_ff) begin
                     state_ff <= S_FIN;
                  end else begin
                     i_ff     <= i_ff + CW'(1);
                     state_ff <= S_ADV;
                  end
               end
            end
            S_SH_WR: begin
               k_ff     <= k_ff - CW'(1);
               state_ff <= S_SH_RD;
            end
            S_ADV: begin
               cur_ff   <= cur_ff + sz_ff;
               left_ff  <= left_ff - sz_ff;
               offs_ff  <= offs_ff + sz_ff;
               state_ff <= S_SKIP;
            end
            S_SKIP: begin
               if (skip_ok) begin
                  room_ff  <= room_c;
                  state_ff <= S_STEP;
               end else begin
                  i_ff     <= i_ff + CW'(1);
                  state_ff <= S_WALK;
               end
            end
            S_STEP: begin
               step_ff  <= step_c;
               state_ff <= S_MOVE;
            end
            S_MOVE: begin
               past_ff  <= past_c;
               cur_ff   <= move_sum[ADDR_BITS-1:0];
               left_ff  <= left_ff - step_ff;
               offs_ff  <= offs_ff + step_ff;
               i_ff     <= i_ff + CW'(1);
               state_ff <= S_WALK;
            end
            S_TAIL: begin
               if (has_room) begin
                  k_ff     <= count_ff;
                  pos_ff   <= i_ff;
                  tail_ff  <= 1'b1;
                  state_ff <= S_SH_RD;
               end else begin
                  status_ff <= STATUS_FULL;
                  state_ff  <= S_FIN;
               end
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_added_ff  <= COUNT_BITS'(added_ff);
                  rsp_count_ff  <= COUNT_BITS'(count_ff);
                  rsp_entry_ff  <= read_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_pieces_added = rsp_added_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_read_start   = rsp_entry_ff.start;
   assign rsp_read_size    = rsp_entry_ff.size;
   assign rsp_read_offset  = rsp_entry_ff.offset;
   assign rsp_read_region  = rsp_entry_ff.region;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_write_in_table: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (CW'(mem_wr_addr) <= count_ff) && has_room)
      else $error("memory write outside the filled table");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_mode == MODE_CLEAR)) |=> (count_ff == '0))
      else $error("clear left entries in the table");

   a_added_bound: assert property (@(posedge clock) disable iff (reset)
      added_ff <= count_ff)
      else $error("more pieces added than entries held");
`endif

endmodule

`default_nettype wire

@@ rtl/igf_mem.sv @@
`default_nettype none

module igf_mem
   import igf_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  wire logic            clock,
   input  wire logic            rd_en,
   input  wire logic [AW-1:0]   rd_addr,
   output      entry_type       rd_data,
   input  wire logic            wr_en,
   input  wire logic [AW-1:0]   wr_addr,
   input  wire entry_type       wr_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // Simple dual port array, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import igf_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int         SLOTS       = 256;
   localparam int         ITEM_GOAL   = 1170;
   localparam longint     CYCLE_LIMIT = 20000000;

   typedef struct packed {
      logic [1:0]             status;
      logic [COUNT_BITS-1:0]  pieces;
      logic [COUNT_BITS-1:0]  count;
      logic [ADDR_BITS-1:0]   start;
      logic [ADDR_BITS-1:0]   size;
      logic [ADDR_BITS-1:0]   offset;
      logic [REGION_BITS-1:0] region;
   } span_rsp_type;

   // Span table model plus the queue of responses it predicts
   class span_table_scoreboard;
      bit [63:0]   starts [SLOTS];
      bit [63:0]   sizes  [SLOTS];
      bit [63:0]   offsets[SLOTS];
      bit [15:0]   regions[SLOTS];
      int unsigned used;
      span_rsp_type expected_rsps[$];
      int          mismatches;
      int          checked;
      int          full_seen;
      int          range_seen;

      function bit place(int unsigned pos, bit [63:0] st, bit [63:0] sz,
                         bit [63:0] of, bit [15:0] rg);
         if (used >= SLOTS || pos > used) return 0;
         for (int unsigned k = used; k > pos; k--) begin
            starts[k]  = starts[k-1];
            sizes[k]   = sizes[k-1];
            offsets[k] = offsets[k-1];
            regions[k] = regions[k-1];
         end
         starts[pos]  = st;
         sizes[pos]   = sz;
         offsets[pos] = of;
         regions[pos] = rg;
         used++;
         return 1;
      endfunction

      function void note_request(logic [1:0] mode, logic [15:0] rid,
                                 logic [63:0] base, logic [63:0] sstart,
                                 logic [63:0] ssize, logic [7:0] idx);
         span_rsp_type r;
         bit [63:0] cur, left, offs, es, elo, gap, sz, room, step, nxt;
         bit        past, ehi;
         int unsigned i;
         r = '{status: STATUS_OK, pieces: '0, count: '0, start: '0, size: '0,
               offset: '0, region: '0};
         case (mode)
            MODE_CLEAR: used = 0;
            MODE_INSERT: begin
               cur = sstart; left = ssize; offs = sstart - base;
               past = 0; i = 0;
               // walk entries, filling free gaps ahead of each one
               while (i < used && left != 0 && !past) begin
                  es = starts[i];
                  elo = es + sizes[i];
                  ehi = elo < es;
                  if (cur < es) begin
                     gap = es - cur;
                     sz = (gap < left) ? gap : left;
                     if (place(i, cur, sz, offs, rid)) begin
                        r.pieces++;
                        i++;
                     end else
                        r.status = STATUS_FULL;
                     cur += sz; left -= sz; offs += sz;
                  end
                  if (left != 0 && cur >= es && (ehi || cur < elo)) begin
                     // skip the part owned by the existing entry
                     room = ehi ? (64'd0 - cur) : (elo - cur);
                     if (ehi) begin
                        step = left;
                        if (room != 0 && left - room < elo) step = left;
                        else if (room != 0) step = room + elo;
                        if (room == 0) step = left;
                     end else
                        step = (room < left) ? room : left;
                     nxt = cur + step;
                     if (nxt < cur || (nxt == 0 && step != 0)) past = 1;
                     cur = nxt; left -= step; offs += step;
                  end
                  i++;
               end
               if (left != 0 && !past) begin
                  if (place((i <= used) ? i : used, cur, left, offs, rid))
                     r.pieces++;
                  else
                     r.status = STATUS_FULL;
               end
               if (r.status == STATUS_FULL) full_seen++;
            end
            MODE_READ: begin
               if (idx < used) begin
                  r.start  = starts[idx];
                  r.size   = sizes[idx];
                  r.offset = offsets[idx];
                  r.region = regions[idx];
               end else begin
                  r.status = STATUS_RANGE;
                  range_seen++;
               end
            end
            default: ;
         endcase
         r.count = COUNT_BITS'(used);
         expected_rsps.push_back(r);
      endfunction

      function void check_response(span_rsp_type got);
         span_rsp_type exp_r;
         checked++;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: response with none pending");
            return;
         end
         exp_r = expected_rsps.pop_front();
         if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"ERROR: rsp %0d exp st=%0d pc=%0d cnt=%0d %h %h %h %h",
                         " got st=%0d pc=%0d cnt=%0d %h %h %h %h"}, checked,
                        exp_r.status, exp_r.pieces, exp_r.count, exp_r.start,
                        exp_r.size, exp_r.offset, exp_r.region, got.status,
                        got.pieces, got.count, got.start, got.size, got.offset,
                        got.region);
         end
      endfunction

      function int pending();
         return expected_rsps.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [1:0]             req_mode;
   logic [REGION_BITS-1:0] req_region_id;
   logic [ADDR_BITS-1:0]   req_region_base;
   logic [ADDR_BITS-1:0]   req_span_start;
   logic [ADDR_BITS-1:0]   req_span_size;
   logic [7:0]             req_entry_index;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [1:0]             rsp_status;
   logic [COUNT_BITS-1:0]  rsp_pieces_added;
   logic [COUNT_BITS-1:0]  rsp_entry_count;
   logic [ADDR_BITS-1:0]   rsp_read_start;
   logic [ADDR_BITS-1:0]   rsp_read_size;
   logic [ADDR_BITS-1:0]   rsp_read_offset;
   logic [REGION_BITS-1:0] rsp_read_region;

   span_table_scoreboard span_sb;
   longint cycles;
   int     items_sent;
   int     hold_request;
   bit     quiet;

   interval_gap_fill_table i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_region_id   (req_region_id),
      .req_region_base (req_region_base),
      .req_span_start  (req_span_start),
      .req_span_size   (req_span_size),
      .req_entry_index (req_entry_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_pieces_added(rsp_pieces_added),
      .rsp_entry_count (rsp_entry_count),
      .rsp_read_start  (rsp_read_start),
      .rsp_read_size   (rsp_read_size),
      .rsp_read_offset (rsp_read_offset),
      .rsp_read_region (rsp_read_region)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   // Response sampling
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         span_sb.check_response('{status: rsp_status, pieces: rsp_pieces_added,
                                  count: rsp_entry_count, start: rsp_read_start,
                                  size: rsp_read_size, offset: rsp_read_offset,
                                  region: rsp_read_region});
   end

   // Toggle between idle-free stretches and stretches with random gaps
   initial begin
      quiet = 0;
      forever begin
         repeat (400) @(posedge clock);
         quiet = ($urandom_range(0, 2) == 0);
      end
   end

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Receiver: random stalls, plus a long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            rsp_ready <= 1'b0;
            hold_request--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            stall_left = pick_gap();
            rsp_ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   task automatic send_req(logic [1:0] mode, logic [15:0] rid, logic [63:0] base,
                           logic [63:0] sstart, logic [63:0] ssize,
                           logic [7:0] idx);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_region_id   <= rid;
      req_region_base <= base;
      req_span_start  <= sstart;
      req_span_size   <= ssize;
      req_entry_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      span_sb.note_request(mode, rid, base, sstart, ssize, idx);
      items_sent++;
   endtask

   task automatic insert_span(logic [15:0] rid, logic [63:0] base,
                              logic [63:0] sstart, logic [63:0] ssize);
      send_req(MODE_INSERT, rid, base, sstart, ssize, 8'd0);
   endtask

   task automatic read_entry(logic [7:0] idx);
      send_req(MODE_READ, 16'($urandom), {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom}, idx);
   endtask

   task automatic clear_table();
      send_req(MODE_CLEAR, 16'($urandom), {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom));
   endtask

   // Hold the sender until every predicted response has arrived
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (span_sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      logic [63:0] window, base, sstart, ssize;
      int          n, r;
      span_sb = new();
      items_sent = 0;
      hold_request = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_CLEAR;
      req_region_id = '0;
      req_region_base = '0;
      req_span_start = '0;
      req_span_size = '0;
      req_entry_index = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty reads, zero size, extremes, top of address space
      read_entry(8'd0);
      insert_span(16'h0001, 64'd0, 64'h100, 64'd0);
      insert_span(16'hFFFF, '1, '1, '1);
      read_entry(8'd0);
      insert_span(16'h0002, 64'd0, 64'h0, 64'h10);
      insert_span(16'h0003, 64'h20, 64'h0, 64'h40);
      read_entry(8'd1);
      read_entry(8'd2);
      read_entry(8'hFF);
      send_req(MODE_UNUSED, '1, '1, '1, '1, '1);
      clear_table();
      // entry running past the top, then an insert crossing it
      insert_span(16'h0010, 64'hFFFF_FFFF_FFFF_F000, 64'hFFFF_FFFF_FFFF_F800,
                  64'h1000);
      insert_span(16'h0011, 64'd0, 64'hFFFF_FFFF_FFFF_E000, 64'h4000);
      insert_span(16'h0012, 64'd5, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20);
      read_entry(8'd0);
      read_entry(8'd1);
      read_entry(8'd2);
      // span covering several holes
      clear_table();
      for (int k = 0; k < 4; k++) insert_span(16'(k), 64'd0, 64'(k * 32 + 8), 64'd8);
      insert_span(16'hABCD, 64'd3, 64'd0, 64'd200);
      for (int k = 0; k < 4; k++) read_entry(8'(k * 2 + 1));
      drain();

      // Fill the whole table, then overflow it
      clear_table();
      for (int k = 0; k < SLOTS; k++)
         insert_span(16'(k), 64'd0, 64'(k) * 64'd16 + 64'h1000, 64'd8);
      insert_span(16'h7777, 64'd0, 64'h0, 64'h4000);
      read_entry(8'd255);
      read_entry(8'($urandom));
      drain();

      // Random episodes: usually a clear, a burst of inserts and stray modes, then reads
      while (items_sent < ITEM_GOAL) begin
         r = $urandom_range(0, 2);
         window = (r == 0) ? 64'd0 : (r == 1) ? {$urandom, $urandom}
                                              : 64'hFFFF_FFFF_FFFF_F000;
         if ($urandom_range(0, 3) != 0) clear_table();
         n = $urandom_range(2, 14);
         for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            base = ($urandom_range(0, 1) != 0) ? window : {$urandom, $urandom};
            sstart = window + 64'($urandom_range(0, 1023));
            ssize = (r < 80) ? 64'($urandom_range(1, 300))
                  : (r < 85) ? 64'd0
                  : (r < 92) ? 64'($urandom_range(256, 2048))
                             : {$urandom, $urandom};
            if (r >= 97)
               send_req(2'($urandom), 16'($urandom), {$urandom, $urandom},
                        {$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom));
            else
               insert_span(16'($urandom), base, sstart, ssize);
         end
         n = $urandom_range(1, 6);
         for (int k = 0; k < n; k++)
            read_entry(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                   : 8'($urandom_range(0, 20)));
         if (items_sent > 500 && items_sent < 530 && hold_request == 0)
            hold_request = 3000;
         if ($urandom_range(0, 9) == 0) drain();
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (span_sb.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d requests, checked %0d responses", items_sent, span_sb.checked);
      $display("Inserts hitting a full table: %0d, out-of-range reads: %0d",
               span_sb.full_seen, span_sb.range_seen);
      if (span_sb.mismatches == 0 && span_sb.pending() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/igf_pkg.sv
rtl/igf_mem.sv
rtl/interval_gap_fill_table.sv
tb/sv/testbench.sv
